// File: src/lsc_pkg.sv
package lsc_pkg;

   // Width of each clipped coordinate on the result port.
   localparam int OUT_W = 16;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_LEFT   = 2'd0;
   localparam csr_idx_type CSR_BOTTOM = 2'd1;
   localparam csr_idx_type CSR_RIGHT  = 2'd2;
   localparam csr_idx_type CSR_TOP    = 2'd3;

   // Visibility classes.
   typedef logic [1:0] vis_type;
   localparam vis_type VIS_INVISIBLE = 2'd0;
   localparam vis_type VIS_FULL      = 2'd1;
   localparam vis_type VIS_CLIPPED   = 2'd2;

   // Queue between the classifier and the interpolator.
   localparam int Q_DEPTH = 8;
   localparam int Q_PTR_W = 3;
   localparam int Q_LVL_W = 4;

   // Width of the fill count of the six-stage classifier.
   localparam int FILL_W = 3;

endpackage

// File: src/line_segment_window_clipper.sv
// Path: a taken word passes the classifier, the queue and the interpolator, whose
//   dividers resolve one bit per stage, before its result strobes.
// Throughput: one segment per cycle while busy is low, since every stage is pipelined.
// Reset is synchronous and active high; it empties the pipeline and the queue and
//   loads the window with left = bottom = 0 and right = top = largest positive value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module line_segment_window_clipper #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_BITS-1:0]      req_start_x,
   input  logic signed [COORD_BITS-1:0]      req_start_y,
   input  logic signed [COORD_BITS-1:0]      req_end_x,
   input  logic signed [COORD_BITS-1:0]      req_end_y,

   output logic                              rsp_valid,
   output lsc_pkg::vis_type                  rsp_visibility,
   output logic signed [lsc_pkg::OUT_W-1:0]  rsp_clipped_start_x,
   output logic signed [lsc_pkg::OUT_W-1:0]  rsp_clipped_start_y,
   output logic signed [lsc_pkg::OUT_W-1:0]  rsp_clipped_end_x,
   output logic signed [lsc_pkg::OUT_W-1:0]  rsp_clipped_end_y,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  lsc_pkg::csr_idx_type              csr_index,
   input  logic signed [COORD_BITS-1:0]      csr_data
);
   import lsc_pkg::*;

   localparam int W   = COORD_BITS + 1;
   localparam int QDW = 2 + 2 * COORD_BITS + 6 * W;
   localparam logic signed [COORD_BITS-1:0] WIN_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   // The window registers. Writes are always taken; the user is to issue them only
   // while no segment is in flight so none sees a half-updated window; not enforced.
   logic signed [COORD_BITS-1:0] left_ff, bottom_ff, right_ff, top_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         right_ff  <= WIN_MAX;
         top_ff    <= WIN_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEFT:   left_ff   <= csr_data;
            CSR_BOTTOM: bottom_ff <= csr_data;
            CSR_RIGHT:  right_ff  <= csr_data;
            CSR_TOP:    top_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The classifier forms the four p/q pairs, keeps the entry and exit
   // parameters as exact fractions and decides the class by cross products.
   logic                  front_valid;
   logic [QDW-1:0]        front_data;
   logic [FILL_W-1:0]     front_fill;
   logic                  take;

   assign take = start & ~busy;

   lsc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (take),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .win_left   (left_ff),
      .win_bottom (bottom_ff),
      .win_right  (right_ff),
      .win_top    (top_ff),
      .out_valid  (front_valid),
      .out_data   (front_data),
      .in_flight  (front_fill)
   );

   // Classified words wait here for the interpolator.
   logic                  q_valid;
   logic [QDW-1:0]        q_data;
   logic [Q_LVL_W-1:0]    q_level;

   lsc_queue #(.WIDTH(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .level     (q_level)
   );

   // New words are held off only when the queue could not absorb a new word on top
   // of everything already inside the classifier. The interpolator drains the queue
   // every cycle, so in practice this never asserts.
   logic [Q_LVL_W:0] occupancy;

   assign occupancy = (Q_LVL_W+1)'(q_level) + (Q_LVL_W+1)'(front_fill);
   assign busy      = (occupancy >= (Q_LVL_W+1)'(Q_DEPTH));

   // The interpolator computes start + d*u for both parameters, rounded to
   // nearest with ties upward, and saturates to the result width.
   lsc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .out_valid (rsp_valid),
      .out_vis   (rsp_visibility),
      .out_sx    (rsp_clipped_start_x),
      .out_sy    (rsp_clipped_start_y),
      .out_ex    (rsp_clipped_end_x),
      .out_ey    (rsp_clipped_end_y)
   );

endmodule

// File: src/lsc_front.sv
module lsc_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic signed [COORD_BITS-1:0]                    start_x,
   input  logic signed [COORD_BITS-1:0]                    start_y,
   input  logic signed [COORD_BITS-1:0]                    end_x,
   input  logic signed [COORD_BITS-1:0]                    end_y,
   input  logic signed [COORD_BITS-1:0]                    win_left,
   input  logic signed [COORD_BITS-1:0]                    win_bottom,
   input  logic signed [COORD_BITS-1:0]                    win_right,
   input  logic signed [COORD_BITS-1:0]                    win_top,
   output logic                                            out_valid,
   output logic [2+2*COORD_BITS+6*(COORD_BITS+1)-1:0]      out_data,
   output logic [lsc_pkg::FILL_W-1:0]                      in_flight
);
   import lsc_pkg::*;

   localparam int W  = COORD_BITS + 1;
   localparam int PW = 2 * W;
   localparam logic signed [W-1:0] ONE_W = W'(1);

   function automatic logic signed [W-1:0] sx(input logic signed [COORD_BITS-1:0] v);
      return W'(v);
   endfunction

   // For one axis, returns {reject, entry num, entry den, exit num, exit den}.
   // The entry fraction is already clamped from below at zero and the exit
   // fraction from above at one.
   function automatic logic [4*W:0] axis_f(input logic signed [W-1:0] d,
                                           input logic signed [W-1:0] ql,
                                           input logic signed [W-1:0] qh);
      logic signed [W-1:0] ea, eb, xa, xb;
      logic rej;
      rej = 1'b0;
      ea  = '0;
      eb  = ONE_W;
      xa  = ONE_W;
      xb  = ONE_W;
      if (d == '0) begin
         rej = ql[W-1] | qh[W-1];
      end else if (!d[W-1]) begin
         ea = -ql;
         eb = d;
         xa = qh;
         xb = d;
      end else begin
         ea = -qh;
         eb = -d;
         xa = ql;
         xb = -d;
      end
      if (ea <= 0) begin
         ea = '0;
         eb = ONE_W;
      end
      if (xa >= xb) begin
         xa = ONE_W;
         xb = ONE_W;
      end
      return {rej, ea, eb, xa, xb};
   endfunction

   // Stage 1: differences and window distances.
   logic                         v1_ff;
   logic signed [COORD_BITS-1:0] x0_1_ff, y0_1_ff;
   logic signed [W-1:0]          dx_1_ff, dy_1_ff, qxl_1_ff, qxh_1_ff, qyl_1_ff, qyh_1_ff;

   // Stage 2: per-axis candidates.
   logic                         v2_ff, rej_2_ff;
   logic signed [COORD_BITS-1:0] x0_2_ff, y0_2_ff;
   logic signed [W-1:0]          dx_2_ff, dy_2_ff;
   logic signed [W-1:0]          exa_2_ff, exb_2_ff, eya_2_ff, eyb_2_ff;
   logic signed [W-1:0]          xxa_2_ff, xxb_2_ff, xya_2_ff, xyb_2_ff;
   logic [4*W:0]                 ax_2_in, ay_2_in;

   // Stage 3: cross products between the axes.
   logic                         v3_ff, rej_3_ff;
   logic signed [COORD_BITS-1:0] x0_3_ff, y0_3_ff;
   logic signed [W-1:0]          dx_3_ff, dy_3_ff;
   logic signed [W-1:0]          exa_3_ff, exb_3_ff, eya_3_ff, eyb_3_ff;
   logic signed [W-1:0]          xxa_3_ff, xxb_3_ff, xya_3_ff, xyb_3_ff;
   logic signed [PW-1:0]         pe1_3_ff, pe2_3_ff, px1_3_ff, px2_3_ff;

   // Stage 4: chosen entry and exit fractions.
   logic                         v4_ff, rej_4_ff;
   logic signed [COORD_BITS-1:0] x0_4_ff, y0_4_ff;
   logic signed [W-1:0]          dx_4_ff, dy_4_ff;
   logic signed [W-1:0]          n1_4_ff, d1_4_ff, n2_4_ff, d2_4_ff;

   // Stage 5: final ordering products.
   logic                         v5_ff, rej_5_ff;
   logic signed [COORD_BITS-1:0] x0_5_ff, y0_5_ff;
   logic signed [W-1:0]          dx_5_ff, dy_5_ff;
   logic signed [W-1:0]          n1_5_ff, d1_5_ff, n2_5_ff, d2_5_ff;
   logic signed [PW-1:0]         pr1_5_ff, pr2_5_ff;

   // Stage 6: classified word.
   logic                         v6_ff;
   vis_type                      vis_6_in;
   logic [2+2*COORD_BITS+6*W-1:0] data_6_ff;

   assign ax_2_in = axis_f(dx_1_ff, qxl_1_ff, qxh_1_ff);
   assign ay_2_in = axis_f(dy_1_ff, qyl_1_ff, qyh_1_ff);

   always_comb begin
      if (rej_5_ff || (pr1_5_ff > pr2_5_ff)) begin
         vis_6_in = VIS_INVISIBLE;
      end else if ((n1_5_ff == '0) && (n2_5_ff == d2_5_ff)) begin
         vis_6_in = VIS_FULL;
      end else begin
         vis_6_in = VIS_CLIPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_1_ff  <= start_x;
      y0_1_ff  <= start_y;
      dx_1_ff  <= sx(end_x) - sx(start_x);
      dy_1_ff  <= sx(end_y) - sx(start_y);
      qxl_1_ff <= sx(start_x) - sx(win_left);
      qxh_1_ff <= sx(win_right) - sx(start_x);
      qyl_1_ff <= sx(start_y) - sx(win_bottom);
      qyh_1_ff <= sx(win_top) - sx(start_y);

      x0_2_ff  <= x0_1_ff;
      y0_2_ff  <= y0_1_ff;
      dx_2_ff  <= dx_1_ff;
      dy_2_ff  <= dy_1_ff;
      rej_2_ff <= ax_2_in[4*W] | ay_2_in[4*W];
      {exa_2_ff, exb_2_ff, xxa_2_ff, xxb_2_ff} <= ax_2_in[4*W-1:0];
      {eya_2_ff, eyb_2_ff, xya_2_ff, xyb_2_ff} <= ay_2_in[4*W-1:0];

      x0_3_ff  <= x0_2_ff;
      y0_3_ff  <= y0_2_ff;
      dx_3_ff  <= dx_2_ff;
      dy_3_ff  <= dy_2_ff;
      rej_3_ff <= rej_2_ff;
      exa_3_ff <= exa_2_ff;
      exb_3_ff <= exb_2_ff;
      eya_3_ff <= eya_2_ff;
      eyb_3_ff <= eyb_2_ff;
      xxa_3_ff <= xxa_2_ff;
      xxb_3_ff <= xxb_2_ff;
      xya_3_ff <= xya_2_ff;
      xyb_3_ff <= xyb_2_ff;
      pe1_3_ff <= PW'(exa_2_ff) * PW'(eyb_2_ff);
      pe2_3_ff <= PW'(eya_2_ff) * PW'(exb_2_ff);
      px1_3_ff <= PW'(xxa_2_ff) * PW'(xyb_2_ff);
      px2_3_ff <= PW'(xya_2_ff) * PW'(xxb_2_ff);

      x0_4_ff  <= x0_3_ff;
      y0_4_ff  <= y0_3_ff;
      dx_4_ff  <= dx_3_ff;
      dy_4_ff  <= dy_3_ff;
      rej_4_ff <= rej_3_ff;
      if (pe1_3_ff > pe2_3_ff) begin
         n1_4_ff <= exa_3_ff;
         d1_4_ff <= exb_3_ff;
      end else begin
         n1_4_ff <= eya_3_ff;
         d1_4_ff <= eyb_3_ff;
      end
      if (px1_3_ff < px2_3_ff) begin
         n2_4_ff <= xxa_3_ff;
         d2_4_ff <= xxb_3_ff;
      end else begin
         n2_4_ff <= xya_3_ff;
         d2_4_ff <= xyb_3_ff;
      end

      x0_5_ff  <= x0_4_ff;
      y0_5_ff  <= y0_4_ff;
      dx_5_ff  <= dx_4_ff;
      dy_5_ff  <= dy_4_ff;
      rej_5_ff <= rej_4_ff;
      n1_5_ff  <= n1_4_ff;
      d1_5_ff  <= d1_4_ff;
      n2_5_ff  <= n2_4_ff;
      d2_5_ff  <= d2_4_ff;
      pr1_5_ff <= PW'(n1_4_ff) * PW'(d2_4_ff);
      pr2_5_ff <= PW'(n2_4_ff) * PW'(d1_4_ff);

      data_6_ff <= {vis_6_in, x0_5_ff, y0_5_ff, dx_5_ff, dy_5_ff,
                    n1_5_ff, d1_5_ff, n2_5_ff, d2_5_ff};
   end

   assign out_valid = v6_ff;
   assign out_data  = data_6_ff;
   assign in_flight = FILL_W'(v1_ff) + FILL_W'(v2_ff) + FILL_W'(v3_ff)
                    + FILL_W'(v4_ff) + FILL_W'(v5_ff) + FILL_W'(v6_ff);

endmodule

// File: src/lsc_queue.sv
module lsc_queue #(
   parameter int WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   output logic                          pop_valid,
   output logic [WIDTH-1:0]              pop_data,
   output logic [lsc_pkg::Q_LVL_W-1:0]   level
);
   import lsc_pkg::*;

   logic [WIDTH-1:0]   mem [0:Q_DEPTH-1];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_LVL_W-1:0] lvl_ff, lvl_in;
   logic               pop;
   logic               pop_valid_ff;
   logic [WIDTH-1:0]   pop_data_ff;

   // The interpolator never stalls, so any stored word leaves at once.
   assign pop    = (lvl_ff != '0);
   assign lvl_in = lvl_ff + Q_LVL_W'(push) - Q_LVL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         lvl_ff       <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         lvl_ff       <= lvl_in;
         pop_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      pop_data_ff <= mem[rd_ptr_ff];
   end

   assign pop_valid = pop_valid_ff;
   assign pop_data  = pop_data_ff;
   assign level     = lvl_ff;

endmodule

// File: src/lsc_div.sv
module lsc_div #(
   parameter int DW = 13,
   parameter int QW = 18
) (
   input  logic                 clock,
   input  logic [DW+QW-1:0]     num,
   input  logic [DW-1:0]        den,
   output logic [QW-1:0]        quo
);
   // Restoring division, one quotient bit per stage, most significant first.
   // The dividend must be below den * 2**QW.
   localparam int NW = DW + QW;

   logic [NW-1:0] rem_w [0:QW];
   logic [DW-1:0] den_w [0:QW];
   logic [QW-1:0] quo_w [0:QW];

   assign rem_w[0] = num;
   assign den_w[0] = den;
   assign quo_w[0] = '0;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;
      logic [NW-1:0] ds;
      logic          ge;
      logic [NW-1:0] rem_ff, rem_in;
      logic [DW-1:0] den_ff;
      logic [QW-1:0] quo_ff, quo_in;

      assign ds     = NW'(den_w[s]) << B;
      assign ge     = (rem_w[s] >= ds);
      assign rem_in = ge ? (rem_w[s] - ds) : rem_w[s];
      assign quo_in = quo_w[s] | (QW'(ge) << B);

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         den_ff <= den_w[s];
         quo_ff <= quo_in;
      end

      assign rem_w[s+1] = rem_ff;
      assign den_w[s+1] = den_ff;
      assign quo_w[s+1] = quo_ff;
   end

   assign quo = quo_w[QW];

endmodule

// File: src/lsc_back.sv
module lsc_back #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic [2+2*COORD_BITS+6*(COORD_BITS+1)-1:0]  in_data,
   output logic                                        out_valid,
   output lsc_pkg::vis_type                            out_vis,
   output logic signed [lsc_pkg::OUT_W-1:0]            out_sx,
   output logic signed [lsc_pkg::OUT_W-1:0]            out_sy,
   output logic signed [lsc_pkg::OUT_W-1:0]            out_ex,
   output logic signed [lsc_pkg::OUT_W-1:0]            out_ey
);
   import lsc_pkg::*;

   localparam int W   = COORD_BITS + 1;
   localparam int PW  = 2 * W;
   localparam int QW  = COORD_BITS + FRAC_BITS + 2;
   localparam int NW  = W + QW;
   localparam int VW  = (COORD_BITS + FRAC_BITS + 4 > OUT_W + 1) ?
                        COORD_BITS + FRAC_BITS + 4 : OUT_W + 1;
   localparam int SW  = 2 + 2 * COORD_BITS;
   localparam logic signed [VW-1:0] BIAS  = VW'(1) << (QW - 1);
   localparam logic signed [VW-1:0] O_MAX = VW'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [VW-1:0] O_MIN = ~O_MAX;

   // Biased dividend for division by 2*den; the quotient is 2^(QW-1) plus
   // floor((2^(F+1)*prod + den) / (2*den)), so that it is never negative.
   function automatic logic [NW-1:0] numer(input logic signed [PW-1:0] prod,
                                           input logic [W-1:0] den);
      logic [NW:0] t;
      t = ((NW+1)'(prod) << (FRAC_BITS + 1)) + (NW+1)'(den) + ((NW+1)'(den) << QW);
      return t[NW-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] place(
         input logic signed [COORD_BITS-1:0] s, input logic [QW-1:0] q);
      logic signed [VW-1:0] v;
      v = (VW'(s) <<< FRAC_BITS) + $signed(VW'(q)) - BIAS;
      if (v > O_MAX) begin
         v = O_MAX;
      end else if (v < O_MIN) begin
         v = O_MIN;
      end
      return v[OUT_W-1:0];
   endfunction

   vis_type                      vis_u;
   logic signed [COORD_BITS-1:0] x0_u, y0_u;
   logic signed [W-1:0]          dx_u, dy_u, n1_u, d1_u, n2_u, d2_u;

   assign {vis_u, x0_u, y0_u, dx_u, dy_u, n1_u, d1_u, n2_u, d2_u} = in_data;

   // Stage 1: products of the direction with the two numerators.
   logic                         v1_ff;
   logic [SW-1:0]                side_1_ff;
   logic [W-1:0]                 den1_1_ff, den2_1_ff;
   logic signed [PW-1:0]         pxa_1_ff, pya_1_ff, pxb_1_ff, pyb_1_ff;

   always_ff @(posedge clock) begin
      side_1_ff <= {vis_u, x0_u, y0_u};
      den1_1_ff <= d1_u;
      den2_1_ff <= d2_u;
      pxa_1_ff  <= PW'(dx_u) * PW'(n1_u);
      pya_1_ff  <= PW'(dy_u) * PW'(n1_u);
      pxb_1_ff  <= PW'(dx_u) * PW'(n2_u);
      pyb_1_ff  <= PW'(dy_u) * PW'(n2_u);
   end

   logic [W-1:0] dd1, dd2;
   logic [QW-1:0] qxa, qya, qxb, qyb;

   assign dd1 = {den1_1_ff[W-2:0], 1'b0};
   assign dd2 = {den2_1_ff[W-2:0], 1'b0};

   lsc_div #(.DW(W), .QW(QW)) u_div_xa (
      .clock (clock), .num (numer(pxa_1_ff, den1_1_ff)), .den (dd1), .quo (qxa));
   lsc_div #(.DW(W), .QW(QW)) u_div_ya (
      .clock (clock), .num (numer(pya_1_ff, den1_1_ff)), .den (dd1), .quo (qya));
   lsc_div #(.DW(W), .QW(QW)) u_div_xb (
      .clock (clock), .num (numer(pxb_1_ff, den2_1_ff)), .den (dd2), .quo (qxb));
   lsc_div #(.DW(W), .QW(QW)) u_div_yb (
      .clock (clock), .num (numer(pyb_1_ff, den2_1_ff)), .den (dd2), .quo (qyb));

   // Class and start point travel alongside the dividers.
   logic [QW-1:0] dv_ff;
   logic [SW-1:0] dpay_ff [0:QW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         dv_ff <= '0;
      end else begin
         v1_ff <= in_valid;
         dv_ff <= {dv_ff[QW-2:0], v1_ff};
      end
   end

   always_ff @(posedge clock) begin
      dpay_ff[0] <= side_1_ff;
      for (int i = 1; i < QW; i++) begin
         dpay_ff[i] <= dpay_ff[i-1];
      end
   end

   vis_type                      vis_f;
   logic signed [COORD_BITS-1:0] x0_f, y0_f;

   assign {vis_f, x0_f, y0_f} = dpay_ff[QW-1];

   logic                    out_valid_ff;
   vis_type                 out_vis_ff;
   logic signed [OUT_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      out_vis_ff <= vis_f;
      if (vis_f == VIS_INVISIBLE) begin
         sx_ff <= '0;
         sy_ff <= '0;
         ex_ff <= '0;
         ey_ff <= '0;
      end else begin
         sx_ff <= place(x0_f, qxa);
         sy_ff <= place(y0_f, qya);
         ex_ff <= place(x0_f, qxb);
         ey_ff <= place(y0_f, qyb);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vis   = out_vis_ff;
   assign out_sx    = sx_ff;
   assign out_sy    = sy_ff;
   assign out_ex    = ex_ff;
   assign out_ey    = ey_ff;

endmodule

// File: test/tb_line_segment_window_clipper.sv
module tb_line_segment_window_clipper;
   timeunit 1ns;
   timeprecision 1ps;

   import lsc_pkg::*;

   localparam int CW = 12;
   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT = 400;
   // Drain time after the last expected word, a bit above the pipeline latency.
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
   } segment_type;

   typedef struct packed {
      vis_type                  vis;
      logic signed [OUT_W-1:0]  csx;
      logic signed [OUT_W-1:0]  csy;
      logic signed [OUT_W-1:0]  cex;
      logic signed [OUT_W-1:0]  cey;
   } clip_word_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [CW-1:0]     req_start_x, req_start_y, req_end_x, req_end_y;
   logic                     rsp_valid;
   vis_type                  rsp_visibility;
   logic signed [OUT_W-1:0]  rsp_clipped_start_x, rsp_clipped_start_y;
   logic signed [OUT_W-1:0]  rsp_clipped_end_x, rsp_clipped_end_y;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_idx_type              csr_index;
   logic signed [CW-1:0]     csr_data;

   line_segment_window_clipper dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_visibility(rsp_visibility),
      .rsp_clipped_start_x(rsp_clipped_start_x), .rsp_clipped_start_y(rsp_clipped_start_y),
      .rsp_clipped_end_x(rsp_clipped_end_x), .rsp_clipped_end_y(rsp_clipped_end_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Segments waiting to be sent, and clip words expected back in order.
   segment_type    pending_segments[$];
   clip_word_type  expected_clips[$];

   // The testbench's own copy of the clip window.
   int  win_left, win_bottom, win_right, win_top;

   int  error_count;
   int  idle_cycles;
   bit  no_gaps;       // When set, the driver sends back to back.

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Endpoint plus d*num/den in fixed point with four fraction bits. The
   // fraction is rounded to nearest with ties going up, and the result
   // saturates to the 16-bit signed range.
   function automatic logic signed [OUT_W-1:0] place_point(longint s, longint d,
                                                             longint num, longint den);
      longint prod, whole, rem, frac, val;
      prod  = d * num;
      whole = prod / den;
      rem   = prod % den;
      if (rem < 0) begin
         rem   += den;
         whole -= 1;
      end
      frac = (rem * 32 + den) / (2 * den);
      val  = (s + whole) * 16 + frac;
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      return val[OUT_W-1:0];
   endfunction

   // Liang-Barsky against the current window. The entry and exit parameters
   // are held as exact fractions so every class decision is exact.
   function automatic clip_word_type clip_segment(segment_type seg);
      clip_word_type w;
      longint x0, y0, dx, dy, a, b;
      longint p[4], q[4];
      longint n1, d1, n2, d2;
      bit rejected;
      x0 = seg.sx;
      y0 = seg.sy;
      dx = longint'(seg.ex) - x0;
      dy = longint'(seg.ey) - y0;
      p[0] = -dx; q[0] = x0 - win_left;
      p[1] = dx;  q[1] = win_right - x0;
      p[2] = -dy; q[2] = y0 - win_bottom;
      p[3] = dy;  q[3] = win_top - y0;
      n1 = 0; d1 = 1; n2 = 1; d2 = 1;
      rejected = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (p[k] == 0) begin
            if (q[k] < 0) rejected = 1'b1;
         end else if (p[k] < 0) begin
            a = -q[k]; b = -p[k];
            if (a * d1 > n1 * b) begin
               n1 = a; d1 = b;
            end
         end else begin
            a = q[k]; b = p[k];
            if (a * d2 < n2 * b) begin
               n2 = a; d2 = b;
            end
         end
      end
      if (n1 * d2 > n2 * d1) rejected = 1'b1;
      w = '0;
      if (rejected) begin
         w.vis = VIS_INVISIBLE;
         return w;
      end
      w.vis = (n1 == 0 && n2 == d2) ? VIS_FULL : VIS_CLIPPED;
      w.csx = place_point(x0, dx, n1, d1);
      w.csy = place_point(y0, dy, n1, d1);
      w.cex = place_point(x0, dx, n2, d2);
      w.cey = place_point(y0, dy, n2, d2);
      return w;
   endfunction

   // Driver: holds a segment on the request ports until it is taken, then
   // waits a randomly drawn gap, or none when no_gaps is set, before offering the next one.
   always @(posedge clock) begin : drive_requests
      int  gap_left;
      bit  next_start;
      segment_type seg;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_clips.push_back(clip_segment({req_start_x, req_start_y,
                                                   req_end_x, req_end_y}));
            next_start = 1'b0;
            gap_left   = no_gaps ? 0 : $urandom_range(0, 6);
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_segments.size() > 0) begin
               seg = pending_segments.pop_front();
               req_start_x <= seg.sx;
               req_start_y <= seg.sy;
               req_end_x   <= seg.ex;
               req_end_y   <= seg.ey;
               next_start  = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Monitor: every strobed word is checked against the oldest expectation.
   always @(posedge clock) begin : check_results
      clip_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_clips.size() == 0) begin
            report_mismatch("clip word with nothing expected");
         end else begin
            want = expected_clips.pop_front();
            if (rsp_visibility !== want.vis)
               report_mismatch($sformatf("visibility %0d, want %0d",
                                         rsp_visibility, want.vis));
            if (rsp_clipped_start_x !== want.csx)
               report_mismatch($sformatf("clipped_start_x %0d, want %0d",
                                         rsp_clipped_start_x, want.csx));
            if (rsp_clipped_start_y !== want.csy)
               report_mismatch($sformatf("clipped_start_y %0d, want %0d",
                                         rsp_clipped_start_y, want.csy));
            if (rsp_clipped_end_x !== want.cex)
               report_mismatch($sformatf("clipped_end_x %0d, want %0d",
                                         rsp_clipped_end_x, want.cex));
            if (rsp_clipped_end_y !== want.cey)
               report_mismatch($sformatf("clipped_end_y %0d, want %0d",
                                         rsp_clipped_end_y, want.cey));
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int clamp_coord(int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
   endfunction

   task automatic add_segment(input int sx, input int sy, input int ex, input int ey);
      segment_type seg;
      seg.sx = sx[CW-1:0];
      seg.sy = sy[CW-1:0];
      seg.ex = ex[CW-1:0];
      seg.ey = ey[CW-1:0];
      pending_segments.push_back(seg);
   endtask

   // A random segment. Most land near the window so that clipping happens
   // often; the rest span the whole field range. Some near ones collapse to
   // a point or lie parallel to an axis.
   task automatic add_random_segment();
      int mode, lo_x, hi_x, lo_y, hi_y, sx, sy, ex, ey;
      mode = $urandom_range(0, 9);
      lo_x = clamp_coord(win_left - 80);
      hi_x = clamp_coord(win_right + 80);
      lo_y = clamp_coord(win_bottom - 80);
      hi_y = clamp_coord(win_top + 80);
      if (lo_x > hi_x) begin
         lo_x = hi_x; hi_x = clamp_coord(win_left + 80);
      end
      if (lo_y > hi_y) begin
         lo_y = hi_y; hi_y = clamp_coord(win_bottom + 80);
      end
      if (mode < 3) begin
         sx = $urandom_range(0, 4095) - 2048;
         sy = $urandom_range(0, 4095) - 2048;
         ex = $urandom_range(0, 4095) - 2048;
         ey = $urandom_range(0, 4095) - 2048;
      end else begin
         sx = $urandom_range(hi_x - lo_x) + lo_x;
         sy = $urandom_range(hi_y - lo_y) + lo_y;
         ex = $urandom_range(hi_x - lo_x) + lo_x;
         ey = $urandom_range(hi_y - lo_y) + lo_y;
      end
      if (mode == 8) begin
         ex = sx; ey = sy;
      end else if (mode == 9) begin
         if ($urandom_range(0, 1)) ex = sx;
         else ey = sy;
      end
      add_segment(sx, sy, ex, ey);
   endtask

   task automatic write_register(input csr_idx_type idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CW-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEFT:   win_left   = value;
         CSR_BOTTOM: win_bottom = value;
         CSR_RIGHT:  win_right  = value;
         default:    win_top    = value;
      endcase
   endtask

   task automatic set_window(input int l, input int b, input int r, input int t);
      write_register(CSR_LEFT, l);
      write_register(CSR_BOTTOM, b);
      write_register(CSR_RIGHT, r);
      write_register(CSR_TOP, t);
   endtask

   // Lets the sender run dry and every expected word come back, then lets
   // the pipeline settle before anything else changes.
   task automatic wait_idle();
      while (pending_segments.size() > 0 || expected_clips.size() > 0 || start)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) add_random_segment();
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_LEFT;
      csr_data    = '0;
      error_count = 0;
      idle_cycles = 0;
      no_gaps     = 1'b0;
      win_left    = 0;
      win_bottom  = 0;
      win_right   = 2047;
      win_top     = 2047;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed segments against the reset window.
      add_segment(10, 10, 100, 200);          // fully inside
      add_segment(-2048, -2048, 2047, 2047);  // diagonal across the whole field
      add_segment(-100, 50, 100, 50);         // horizontal, enters on the left
      add_segment(50, 2047, 50, -2048);       // vertical, leaves at the bottom
      add_segment(-10, -10, -500, -20);       // entirely outside
      add_segment(300, 300, 300, 300);        // a point inside
      add_segment(-1, 300, -1, 300);          // a point just outside
      add_segment(0, 0, 2047, 2047);          // exactly on the window corners
      add_segment(-1, 0, 0, -1);              // passes just outside the corner
      add_segment(-2048, 2047, 2047, -2048);  // anti-diagonal
      add_segment(-3, 7, 5, -2);              // crosses the left and bottom edges, fractional ends
      add_segment(2047, -2048, -2048, 2047);
      add_segment(-2048, 5, -2048, 900);      // parallel outside on the left
      add_segment(0, -2048, 0, 2047);         // along the left edge
      wait_idle();

      // Largest possible window.
      set_window(-2048, -2048, 2047, 2047);
      add_segment(-2048, -2048, 2047, 2047);
      add_segment(2047, 2047, -2048, -2048);
      add_segment(-2048, 0, -2048, 0);
      wait_idle();

      // Small window with a long segment gives fine fractional ends.
      set_window(-3, -5, 4, 2);
      add_segment(-2048, -1000, 2047, 1001);
      add_segment(-7, 1, 9, -3);
      run_random(40);

      // Inverted window: left above right and bottom above top.
      set_window(100, 50, -100, -50);
      add_segment(0, 0, 10, 10);
      add_segment(0, 0, 0, 0);
      run_random(30);

      // Several random windows, with and without idle cycles on the sender.
      for (int ph = 0; ph < 8; ph++) begin
         no_gaps = (ph % 3 == 1);
         set_window($urandom_range(0, 2047) - 2048, $urandom_range(0, 2047) - 2048,
                    $urandom_range(0, 2047), $urandom_range(0, 2047));
         run_random(60);
      end
      no_gaps = 1'b0;

      // Back to the default window with random content.
      set_window(0, 0, 2047, 2047);
      run_random(50);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
